>>> rtl/lcma_pkg.sv
package lcma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 24;
  localparam int POW_W    = 32;
  localparam int EY_W     = 35;
  localparam int P_W      = EY_W + SAMPLE_W;
  localparam int G_W      = EY_W + 2;
  localparam int MG_W     = 18;
  localparam int LK_W     = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_LIGHT = 2'd1;
  localparam logic [1:0] MODE_AGGR  = 2'd2;
  localparam logic [1:0] MODE_ALT_OFF = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_EQ_MODE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_ENABLE = 8'd1;

  localparam logic signed [TAP_W-1:0] ONE_Q22     = 24'sd4194304;
  localparam logic signed [20:0]      MU_LIGHT    = 21'sd214748;
  localparam logic signed [20:0]      MU_AGGR     = 21'sd858993;
  localparam logic signed [18:0]      LEAK_LIGHT  = 19'sd214748;
  localparam logic signed [18:0]      LEAK_AGGR   = 19'sd42950;
  localparam logic signed [TAP_W-1:0] CLEAK_LIGHT = 24'sd210;
  localparam logic signed [TAP_W-1:0] CLEAK_AGGR  = 24'sd42;

  typedef struct packed {
    logic signed [TAP_W-1:0] re;
    logic signed [TAP_W-1:0] im;
  } tap_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cplx_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [TAP_W-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[TAP_W-1:0];
  endfunction

endpackage

>>> rtl/lcma_ifs.sv
interface lcma_sample_if;
  logic valid;
  logic ready;
  logic signed [lcma_pkg::SAMPLE_W-1:0] sample_re;
  logic signed [lcma_pkg::SAMPLE_W-1:0] sample_im;
  logic restart;
  modport source (output valid, sample_re, sample_im, restart, input ready);
  modport sink (input valid, sample_re, sample_im, restart, output ready);
endinterface

interface lcma_result_if;
  logic valid;
  logic ready;
  logic signed [lcma_pkg::SAMPLE_W-1:0] out_re;
  logic signed [lcma_pkg::SAMPLE_W-1:0] out_im;
  logic [lcma_pkg::POW_W-1:0] envelope_error;
  modport source (output valid, out_re, out_im, envelope_error, input ready);
  modport sink (input valid, out_re, out_im, envelope_error, output ready);
endinterface

interface lcma_cfg_if;
  logic valid;
  logic ready;
  logic [lcma_pkg::CFG_IDX_W-1:0] index;
  logic [lcma_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/lcma_store.sv
module lcma_store #(
  parameter int NTAPS = 17,
  parameter int AW = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic rd_en,
  input  logic [AW-1:0] rd_tap_addr,
  input  logic [AW-1:0] rd_hist_addr,
  input  logic hist_we,
  input  logic [AW-1:0] hist_addr,
  input  lcma_pkg::cplx_t hist_wdata,
  input  logic tap_we,
  input  logic [AW-1:0] tap_waddr,
  input  lcma_pkg::tap_t tap_wdata,
  output lcma_pkg::tap_t rd_tap,
  output lcma_pkg::cplx_t rd_hist
);

  localparam int CENTRE = NTAPS / 2;

  lcma_pkg::tap_t  tap_mem [NTAPS];
  lcma_pkg::cplx_t hist_mem [NTAPS];
  logic [NTAPS-1:0] tap_vld;
  logic [NTAPS-1:0] hist_vld;
  lcma_pkg::tap_t  tap_q;
  lcma_pkg::cplx_t hist_q;
  logic tap_vq, hist_vq, centre_q;

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    if (hist_we) begin
      hist_mem[hist_addr] <= hist_wdata;
    end
    if (rd_en) begin
      tap_q    <= tap_mem[rd_tap_addr];
      hist_q   <= hist_mem[rd_hist_addr];
      tap_vq   <= tap_vld[rd_tap_addr];
      hist_vq  <= hist_vld[rd_hist_addr];
      centre_q <= (rd_tap_addr == AW'(CENTRE));
    end
  end

  // entries not written since the last clear read as their reset value
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      tap_vld  <= '0;
      hist_vld <= '0;
    end else begin
      if (tap_we) tap_vld[tap_waddr] <= 1'b1;
      if (hist_we) hist_vld[hist_addr] <= 1'b1;
    end
  end

  always_comb begin
    if (tap_vq) begin
      rd_tap = tap_q;
    end else begin
      rd_tap.re = centre_q ? lcma_pkg::ONE_Q22 : '0;
      rd_tap.im = '0;
    end
    rd_hist = hist_vq ? hist_q : '0;
  end

endmodule

>>> rtl/lcma_tap_upd.sv
module lcma_tap_upd #(
  parameter int NTAPS = 17,
  parameter int AW = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [AW-1:0] in_k,
  input  lcma_pkg::tap_t tap,
  input  lcma_pkg::cplx_t hist,
  input  logic signed [lcma_pkg::EY_W-1:0] eyr,
  input  logic signed [lcma_pkg::EY_W-1:0] eyi,
  input  logic aggr,
  output logic tap_we,
  output logic [AW-1:0] tap_waddr,
  output lcma_pkg::tap_t tap_wdata,
  output logic busy
);

  localparam int CENTRE = NTAPS / 2;
  localparam int PS_W = lcma_pkg::P_W + 1;
  localparam int LP_W = lcma_pkg::TAP_W + 19;
  localparam int MP_W = lcma_pkg::G_W + 21;

  logic a_v, b_v, c_v;
  logic [AW-1:0] a_k, b_k, c_k;
  logic signed [lcma_pkg::P_W-1:0] p1, p2, p3, p4;
  logic signed [LP_W-1:0] lr, li;
  logic signed [lcma_pkg::TAP_W-1:0] a_tr, a_ti, b_tr, b_ti, c_tr, c_ti;
  logic signed [lcma_pkg::G_W-1:0] gr, gi;
  logic signed [lcma_pkg::LK_W-1:0] b_lr, b_li, c_lr, c_li;
  logic signed [lcma_pkg::MG_W-1:0] mgr, mgi;
  logic signed [20:0] mu;
  logic signed [18:0] leak;
  logic signed [lcma_pkg::TAP_W-1:0] cleak;
  logic signed [PS_W-1:0] sr, si;
  logic signed [LP_W-1:0] lr_r, li_r;
  logic signed [MP_W-1:0] mr_r, mi_r;
  logic signed [lcma_pkg::TAP_W+1:0] nr, ni;

  assign mu    = aggr ? lcma_pkg::MU_AGGR : lcma_pkg::MU_LIGHT;
  assign leak  = aggr ? lcma_pkg::LEAK_AGGR : lcma_pkg::LEAK_LIGHT;
  assign cleak = aggr ? lcma_pkg::CLEAK_AGGR : lcma_pkg::CLEAK_LIGHT;

  assign sr   = PS_W'(p1) + PS_W'(p2) + PS_W'(2**14);
  assign si   = PS_W'(p3) - PS_W'(p4) + PS_W'(2**14);
  assign lr_r = lr + LP_W'(64'sd2147483648);
  assign li_r = li + LP_W'(64'sd2147483648);
  assign mr_r = MP_W'(mu * gr) + MP_W'(64'sd549755813888);
  assign mi_r = MP_W'(mu * gi) + MP_W'(64'sd549755813888);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    p1 <= eyr * hist.re;
    p2 <= eyi * hist.im;
    p3 <= eyi * hist.re;
    p4 <= eyr * hist.im;
    lr <= tap.re * leak;
    li <= tap.im * leak;
    a_tr <= tap.re;
    a_ti <= tap.im;
    a_k  <= in_k;
    gr   <= lcma_pkg::G_W'(sr >>> 15);
    gi   <= lcma_pkg::G_W'(si >>> 15);
    b_lr <= lcma_pkg::LK_W'(lr_r >>> 32);
    b_li <= lcma_pkg::LK_W'(li_r >>> 32);
    b_tr <= a_tr;
    b_ti <= a_ti;
    b_k  <= a_k;
    mgr  <= lcma_pkg::MG_W'(mr_r >>> 40);
    mgi  <= lcma_pkg::MG_W'(mi_r >>> 40);
    c_lr <= b_lr;
    c_li <= b_li;
    c_tr <= b_tr;
    c_ti <= b_ti;
    c_k  <= b_k;
  end

  // leak and step, then the centre tap gets its leak back
  always_comb begin
    nr = 26'(c_tr) - 26'(c_lr) - 26'(mgr);
    ni = 26'(c_ti) - 26'(c_li) - 26'(mgi);
    if (c_k == AW'(CENTRE)) nr = nr + 26'(cleak);
    tap_wdata.re = lcma_pkg::sat24(64'(nr));
    tap_wdata.im = lcma_pkg::sat24(64'(ni));
  end

  assign tap_we    = c_v;
  assign tap_waddr = c_k;
  assign busy      = in_valid | a_v | b_v | c_v;

endmodule

>>> rtl/leaky_cma_complex_equalizer_unit.sv
// Leaky dispersion-CMA complex FIR equalizer.
// Channels: "sample" carries one complex Q1.15 beat (sample_re, sample_im,
// restart); "result" returns one beat per sample (out_re, out_im,
// envelope_error); "cfg" writes eq_mode (index 0) and adapt_enable (index 1)
// and is always ready. Write configuration only while the block is idle.
// Taps and history live in synchronous-read memories. Outside off mode, each
// sample runs a filter pass over all taps through one shared complex MAC,
// then, with adaptation on, a tap update pass through the update pipeline;
// both passes read the same memory port. The next sample is taken once the
// previous one has reached the output register.
// Reset and restart clear the valid bits of both memories at once, so taps
// read as a centre delta and history as zero with no clearing pass.
// A stalled receiver holds the result beat; the block may take one more
// sample and then waits with its finished result until the output frees.
module leaky_cma_complex_equalizer_unit #(
  parameter int TAP_COUNT = 17
) (
  input logic clk,
  input logic rst,
  lcma_sample_if.sink sample,
  lcma_result_if.source result,
  lcma_cfg_if.sink cfg
);

  localparam int NTAPS = TAP_COUNT | 1;
  localparam int AW = $clog2(NTAPS);
  localparam int SW = lcma_pkg::SAMPLE_W;
  localparam int FP_W = lcma_pkg::TAP_W + SW + 1;
  localparam int ACC_W = FP_W + AW;

  typedef enum logic [3:0] {
    IDLE, PRE, FILT, FDRAIN, YCALC, ERR1, ERR2, EY, UPD, UDRAIN, FINISH
  } state_t;

  state_t state;
  logic [1:0] mode;
  logic adapt;
  logic [lcma_pkg::POW_W-1:0] trace, mean;
  logic primed;
  logic [AW-1:0] slot, cnt, idx, rd_k_q;
  logic off_item;
  logic signed [SW-1:0] x_re, x_im, y_re, y_im;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [FP_W-1:0] f_pre, f_pim;
  logic f_v1, f_v2, u_v1;
  logic signed [32:0] sq_y;
  logic signed [33:0] err;
  logic signed [lcma_pkg::EY_W-1:0] eyr, eyi;
  logic out_valid;
  logic signed [SW-1:0] o_re, o_im;
  logic [lcma_pkg::POW_W-1:0] o_err;

  lcma_pkg::tap_t  rd_tap, upd_wdata;
  lcma_pkg::cplx_t rd_hist, hist_wdata;
  logic upd_we, upd_busy, store_clear, rd_en, accept, mode_change;
  logic [AW-1:0] upd_waddr;
  logic [1:0] cfg_mode;

  logic signed [32:0] p_x;
  logic signed [33:0] mean_diff;
  logic [lcma_pkg::POW_W-1:0] mean_next;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [33:0] err_c, aerr;
  logic signed [34:0] trace_diff;
  logic [lcma_pkg::POW_W-1:0] trace_next;
  logic signed [49:0] ey_re_r, ey_im_r;

  assign accept = sample.valid && sample.ready;
  assign sample.ready = (state == IDLE);
  assign cfg.ready = 1'b1;
  assign cfg_mode = cfg.data[1:0];
  assign mode_change = cfg.valid && (cfg.index == lcma_pkg::REG_EQ_MODE) && (cfg_mode != mode);
  assign store_clear = (accept && sample.restart) || mode_change;

  assign result.valid = out_valid;
  assign result.out_re = o_re;
  assign result.out_im = o_im;
  assign result.envelope_error = o_err;

  // power of the new sample and its running mean
  assign p_x = 33'(x_re * x_re) + 33'(x_im * x_im);
  assign mean_diff = 34'(p_x) - $signed({2'b0, mean});
  assign mean_next = primed ? 32'($signed({2'b0, mean}) + (mean_diff >>> 16)) : p_x[31:0];

  assign acc_re_r = acc_re + ACC_W'(2**21);
  assign acc_im_r = acc_im + ACC_W'(2**21);

  assign err_c = 34'(sq_y) - $signed({2'b0, mean});
  assign aerr = err[33] ? -err : err;
  assign trace_diff = 35'(aerr) - $signed({3'b0, trace});
  assign trace_next = 32'($signed({4'b0, trace}) + 36'(trace_diff >>> 8));
  assign ey_re_r = 50'(y_re * err) + 50'(2**14);
  assign ey_im_r = 50'(y_im * err) + 50'(2**14);

  assign rd_en = (state == FILT) || (state == UPD);
  assign hist_wdata.re = x_re;
  assign hist_wdata.im = x_im;

  lcma_store #(.NTAPS(NTAPS), .AW(AW)) u_store (
    .clk(clk),
    .rst(rst),
    .clear(store_clear),
    .rd_en(rd_en),
    .rd_tap_addr(cnt),
    .rd_hist_addr(idx),
    .hist_we(state == PRE),
    .hist_addr(slot),
    .hist_wdata(hist_wdata),
    .tap_we(upd_we),
    .tap_waddr(upd_waddr),
    .tap_wdata(upd_wdata),
    .rd_tap(rd_tap),
    .rd_hist(rd_hist)
  );

  lcma_tap_upd #(.NTAPS(NTAPS), .AW(AW)) u_upd (
    .clk(clk),
    .rst(rst),
    .in_valid(u_v1),
    .in_k(rd_k_q),
    .tap(rd_tap),
    .hist(rd_hist),
    .eyr(eyr),
    .eyi(eyi),
    .aggr(mode == lcma_pkg::MODE_AGGR),
    .tap_we(upd_we),
    .tap_waddr(upd_waddr),
    .tap_wdata(upd_wdata),
    .busy(upd_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      mode      <= lcma_pkg::MODE_OFF;
      adapt     <= 1'b1;
      trace     <= '0;
      mean      <= '0;
      primed    <= 1'b0;
      slot      <= '0;
      f_v1      <= 1'b0;
      f_v2      <= 1'b0;
      u_v1      <= 1'b0;
    end else begin
      f_v1   <= (state == FILT);
      f_v2   <= f_v1;
      u_v1   <= (state == UPD);
      rd_k_q <= cnt;
      // shared complex MAC: multiply one beat, accumulate the next
      if (f_v1) begin
        f_pre <= FP_W'(rd_tap.re * rd_hist.re) - FP_W'(rd_tap.im * rd_hist.im);
        f_pim <= FP_W'(rd_tap.re * rd_hist.im) + FP_W'(rd_tap.im * rd_hist.re);
      end
      if (f_v2) begin
        acc_re <= acc_re + ACC_W'(f_pre);
        acc_im <= acc_im + ACC_W'(f_pim);
      end
      // drop the beat once taken, unless a new one loads this cycle
      if (result.valid && result.ready && state != FINISH) out_valid <= 1'b0;

      if (cfg.valid) begin
        if (cfg.index == lcma_pkg::REG_EQ_MODE) begin
          if (mode_change) begin
            mode   <= cfg_mode;
            mean   <= '0;
            primed <= 1'b0;
            slot   <= '0;
          end
        end else if (cfg.index == lcma_pkg::REG_ADAPT_ENABLE) begin
          adapt <= cfg.data[0];
        end
      end

      case (state)
        IDLE: begin
          if (sample.valid) begin
            x_re     <= sample.sample_re;
            x_im     <= sample.sample_im;
            off_item <= (mode == lcma_pkg::MODE_OFF) || (mode == lcma_pkg::MODE_ALT_OFF);
            if (sample.restart) begin
              trace  <= '0;
              mean   <= '0;
              primed <= 1'b0;
              slot   <= '0;
            end
            state <= ((mode == lcma_pkg::MODE_OFF) || (mode == lcma_pkg::MODE_ALT_OFF))
                     ? FINISH : PRE;
          end
        end
        PRE: begin
          mean   <= mean_next;
          primed <= 1'b1;
          acc_re <= '0;
          acc_im <= '0;
          cnt    <= '0;
          idx    <= slot;
          state  <= FILT;
        end
        FILT, UPD: begin
          cnt <= cnt + 1'b1;
          idx <= (idx == '0) ? AW'(NTAPS - 1) : idx - 1'b1;
          if (cnt == AW'(NTAPS - 1)) state <= (state == FILT) ? FDRAIN : UDRAIN;
        end
        FDRAIN: begin
          if (!f_v1 && !f_v2) state <= YCALC;
        end
        YCALC: begin
          y_re  <= lcma_pkg::sat16(64'(acc_re_r >>> 22));
          y_im  <= lcma_pkg::sat16(64'(acc_im_r >>> 22));
          state <= ERR1;
        end
        ERR1: begin
          sq_y  <= 33'(y_re * y_re) + 33'(y_im * y_im);
          state <= adapt ? ERR2 : FINISH;
        end
        ERR2: begin
          err   <= err_c;
          state <= EY;
        end
        EY: begin
          eyr   <= lcma_pkg::EY_W'(ey_re_r >>> 15);
          eyi   <= lcma_pkg::EY_W'(ey_im_r >>> 15);
          trace <= trace_next;
          cnt   <= '0;
          idx   <= slot;
          state <= UPD;
        end
        UDRAIN: begin
          if (!u_v1 && !upd_busy) state <= FINISH;
        end
        FINISH: begin
          // hold the result until the output register frees
          if (!out_valid || result.ready) begin
            o_re      <= off_item ? x_re : y_re;
            o_im      <= off_item ? x_im : y_im;
            o_err     <= trace;
            out_valid <= 1'b1;
            if (!off_item) slot <= (slot == AW'(NTAPS - 1)) ? '0 : slot + 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= AW'(NTAPS - 1))
    else $error("write slot out of range");

  a_no_tap_write_in_filter: assert property (@(posedge clk) disable iff (rst)
    (state == FILT || state == FDRAIN) |-> !upd_we)
    else $error("tap write during filter pass");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && (!out_valid || result.ready)) |=> result.valid)
    else $error("finished result not presented");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid && $stable(o_err))
    else $error("stalled result dropped");

endmodule
